FILE: rtl/core/pdbwl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdbwl_pkg;

  localparam int unsigned WINDOW_MAX_DEFAULT = 256;

  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CHANCE_W = 14;
  localparam int unsigned WPKT_W   = 9;
  localparam int unsigned LIMIT_W  = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned INDEX_W  = 3;

  // A chance at or above this value drops every packet of an enabled direction.
  localparam logic [CHANCE_W-1:0] FULL_CHANCE = 14'd10000;

  typedef enum logic [INDEX_W-1:0] {
    REG_DROP_INBOUND_ON  = 3'd0,
    REG_DROP_OUTBOUND_ON = 3'd1,
    REG_DROP_CHANCE      = 3'd2,
    REG_LIMITER_ON       = 3'd3,
    REG_WINDOW_PACKETS   = 3'd4,
    REG_BYTE_LIMIT       = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    VERDICT_FORWARD = 2'd0,
    VERDICT_RANDOM  = 2'd1,
    VERDICT_LIMIT   = 2'd2
  } verdict_t;

  typedef struct packed {
    logic                drop_inbound_on;
    logic                drop_outbound_on;
    logic [CHANCE_W-1:0] drop_chance;
    logic                limiter_on;
    logic [WPKT_W-1:0]   window_packets;
    logic [LIMIT_W-1:0]  byte_limit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/packet_drop_byte_window_limiter_top.sv
// Packet drop decision with a sliding-window byte limiter.
//
// Input channel: in_valid / in_stall with packet_length, is_outbound and
// random_draw. Output channel: out_valid / out_stall with forward and verdict.
// A transfer happens on a rising edge where valid is high and stall is low.
// Each input transfer yields exactly one result, registered: it appears on the
// output in the cycle after the input transfer. Throughput is one packet per
// cycle while out_stall is low. The window lengths live in a ring memory
// whose read register is kept loaded with the oldest entry, so the decision and
// the ring write for one packet complete in the cycle it is taken.
// While a result waits under out_stall, in_stall is raised; a new packet is
// taken in the same cycle that the waiting result is transferred.
// Synchronous reset (rst) loads the register defaults and empties the window;
// in_stall stays high while rst is asserted. No clearing pass is needed, so
// packets are accepted from the first cycle after reset.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// A write to limiter_on, window_packets or byte_limit empties the window.
`timescale 1ns / 1ps
`default_nettype none

module packet_drop_byte_window_limiter_top #(
  parameter int unsigned WINDOW_MAX = pdbwl_pkg::WINDOW_MAX_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pdbwl_pkg::INDEX_W-1:0]   cfg_index,
  input  wire logic [pdbwl_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [pdbwl_pkg::LEN_W-1:0]     packet_length,
  input  wire logic                            is_outbound,
  input  wire logic [pdbwl_pkg::CHANCE_W-1:0]  random_draw,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 forward,
  output logic [1:0]                           verdict
);

  pdbwl_pkg::cfg_t      cfg;
  logic                 clear;
  logic                 fire;
  pdbwl_pkg::verdict_t  decision;

  assign in_stall = rst || (out_valid && out_stall);
  assign fire     = in_valid && !in_stall;

  pdbwl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .clear     (clear)
  );

  pdbwl_window #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .clear         (clear),
    .fire          (fire),
    .packet_length (packet_length),
    .is_outbound   (is_outbound),
    .random_draw   (random_draw),
    .verdict       (decision)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      forward <= (decision == pdbwl_pkg::VERDICT_FORWARD);
      verdict <= decision;
    end
  end

  a_limit_needs_limiter: assert property (@(posedge clk) disable iff (rst)
    (fire && !cfg.limiter_on) |=> (verdict != pdbwl_pkg::VERDICT_LIMIT))
    else $error("rate limit drop while the limiter is off");

  a_full_chance_drops: assert property (@(posedge clk) disable iff (rst)
    (fire && (cfg.drop_chance >= pdbwl_pkg::FULL_CHANCE) &&
     (is_outbound ? cfg.drop_outbound_on : cfg.drop_inbound_on))
    |=> (out_valid && (verdict == pdbwl_pkg::VERDICT_RANDOM)))
    else $error("full drop chance did not drop the packet");

  a_forward_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (forward == (verdict == pdbwl_pkg::VERDICT_FORWARD)))
    else $error("forward flag disagrees with verdict");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted packet produced no result");

endmodule

`default_nettype wire

FILE: rtl/core/pdbwl_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pdbwl_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pdbwl_pkg::INDEX_W-1:0]   cfg_index,
  input  wire logic [pdbwl_pkg::CFG_W-1:0]     cfg_data,
  output pdbwl_pkg::cfg_t                      cfg,
  output logic                                 clear
);

  pdbwl_pkg::reg_index_t index;

  assign index = pdbwl_pkg::reg_index_t'(cfg_index);

  // Any write to a limiter register restarts the window, even with the same value.
  always_comb begin
    clear = 1'b0;
    if (cfg_we) begin
      case (index)
        pdbwl_pkg::REG_LIMITER_ON,
        pdbwl_pkg::REG_WINDOW_PACKETS,
        pdbwl_pkg::REG_BYTE_LIMIT: clear = 1'b1;
        default:                   clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drop_inbound_on  <= 1'b1;
      cfg.drop_outbound_on <= 1'b1;
      cfg.drop_chance      <= 14'd1000;
      cfg.limiter_on       <= 1'b0;
      cfg.window_packets   <= 9'd1;
      cfg.byte_limit       <= 24'd1;
    end else if (cfg_we) begin
      case (index)
        pdbwl_pkg::REG_DROP_INBOUND_ON:  cfg.drop_inbound_on  <= cfg_data[0];
        pdbwl_pkg::REG_DROP_OUTBOUND_ON: cfg.drop_outbound_on <= cfg_data[0];
        pdbwl_pkg::REG_DROP_CHANCE:
          cfg.drop_chance <= cfg_data[pdbwl_pkg::CHANCE_W-1:0];
        pdbwl_pkg::REG_LIMITER_ON:       cfg.limiter_on       <= cfg_data[0];
        pdbwl_pkg::REG_WINDOW_PACKETS:
          cfg.window_packets <= cfg_data[pdbwl_pkg::WPKT_W-1:0];
        pdbwl_pkg::REG_BYTE_LIMIT:
          cfg.byte_limit <= cfg_data[pdbwl_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pdbwl_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module pdbwl_ring #(
  parameter int unsigned WINDOW_MAX = pdbwl_pkg::WINDOW_MAX_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(WINDOW_MAX)-1:0]  waddr,
  input  wire logic [pdbwl_pkg::LEN_W-1:0]    wdata,
  input  wire logic [$clog2(WINDOW_MAX)-1:0]  raddr,
  output logic      [pdbwl_pkg::LEN_W-1:0]    rdata
);

  logic [pdbwl_pkg::LEN_W-1:0] mem [WINDOW_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A write to the entry being read shows up in the read data the next cycle.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pdbwl_window.sv
`timescale 1ns / 1ps
`default_nettype none

module pdbwl_window #(
  parameter int unsigned WINDOW_MAX = pdbwl_pkg::WINDOW_MAX_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pdbwl_pkg::cfg_t                   cfg,
  input  wire logic                              clear,
  input  wire logic                              fire,
  input  wire logic [pdbwl_pkg::LEN_W-1:0]       packet_length,
  input  wire logic                              is_outbound,
  input  wire logic [pdbwl_pkg::CHANCE_W-1:0]    random_draw,
  output pdbwl_pkg::verdict_t                    verdict
);

  localparam int unsigned PosW  = $clog2(WINDOW_MAX);
  localparam int unsigned FillW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LimW  = pdbwl_pkg::LIMIT_W;

  logic [PosW-1:0]               pos;
  logic [PosW-1:0]               pos_next;
  logic [FillW-1:0]              fill;
  logic [FillW-1:0]              fill_next;
  logic [LimW-1:0]               total;
  logic [LimW-1:0]               total_next;
  logic [FillW-1:0]              size;
  logic [FillW-1:0]              pos_inc;
  logic [PosW-1:0]               pos_adv;
  logic                          full;
  logic [pdbwl_pkg::LEN_W-1:0]   oldest;
  logic [pdbwl_pkg::LEN_W-1:0]   evicted;
  logic [LimW-1:0]               base;
  logic [LimW:0]                 want;
  logic                          dir_on;
  logic                          hit;
  logic                          admit;
  logic                          commit;

  always_comb begin
    if (cfg.window_packets == '0) begin
      size = FillW'(1);
    end else if (32'(cfg.window_packets) > WINDOW_MAX) begin
      size = FillW'(WINDOW_MAX);
    end else begin
      size = FillW'(cfg.window_packets);
    end
  end

  // The slot at pos is the oldest entry once the window is full; the ring keeps
  // its contents in the read register so the decision needs no read wait.
  assign full    = (fill >= size);
  assign evicted = full ? oldest : '0;
  assign base    = (total >= LimW'(evicted)) ? (total - LimW'(evicted)) : '0;
  assign want    = {1'b0, base} + (LimW + 1)'(packet_length);
  assign admit   = (want <= {1'b0, cfg.byte_limit});

  assign dir_on = is_outbound ? cfg.drop_outbound_on : cfg.drop_inbound_on;
  assign hit    = (cfg.drop_chance >= pdbwl_pkg::FULL_CHANCE) ||
                  (random_draw < cfg.drop_chance);

  always_comb begin
    priority if (dir_on && hit) begin
      verdict = pdbwl_pkg::VERDICT_RANDOM;
    end else if (cfg.limiter_on && !admit) begin
      verdict = pdbwl_pkg::VERDICT_LIMIT;
    end else begin
      verdict = pdbwl_pkg::VERDICT_FORWARD;
    end
  end

  assign commit = fire && cfg.limiter_on && !(dir_on && hit) && admit;

  assign pos_inc = FillW'(pos) + FillW'(1);
  assign pos_adv = (pos_inc == size) ? '0 : pos_inc[PosW-1:0];

  always_comb begin
    pos_next   = pos;
    fill_next  = fill;
    total_next = total;
    if (clear) begin
      pos_next   = '0;
      fill_next  = '0;
      total_next = '0;
    end else if (commit) begin
      pos_next   = pos_adv;
      fill_next  = full ? fill : fill + FillW'(1);
      total_next = want[LimW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      fill  <= '0;
      total <= '0;
    end else begin
      pos   <= pos_next;
      fill  <= fill_next;
      total <= total_next;
    end
  end

  pdbwl_ring #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (commit),
    .waddr (pos),
    .wdata (packet_length),
    .raddr (pos_next),
    .rdata (oldest)
  );

endmodule

`default_nettype wire

FILE: tb/sv/packet_drop_byte_window_limiter_top_test.sv
`timescale 1ns / 1ps

module packet_drop_byte_window_limiter_top_test;
  import pdbwl_pkg::*;

  localparam int unsigned WINDOW_MAX = WINDOW_MAX_DEFAULT;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned MAX_MISMATCH_LINES = 40;
  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct {
    logic [LEN_W-1:0]    len;
    logic                outbound;
    logic [CHANCE_W-1:0] draw;
  } packet_t;

  typedef struct {
    logic     fwd;
    verdict_t code;
  } fate_t;

  class packet_fate_predictor;
    cfg_t             cfg;
    logic [LEN_W-1:0] length_hist [WINDOW_MAX];
    int unsigned      slot_next;
    int unsigned      held;
    int unsigned      bytes_held;
    fate_t            fates_due [$];
    int unsigned      errors;

    function new();
      cfg.drop_inbound_on  = 1'b1;
      cfg.drop_outbound_on = 1'b1;
      cfg.drop_chance      = 14'd1000;
      cfg.limiter_on       = 1'b0;
      cfg.window_packets   = 9'd1;
      cfg.byte_limit       = 24'd1;
      empty_window();
      errors = 0;
    endfunction

    function void empty_window();
      slot_next  = 0;
      held       = 0;
      bytes_held = 0;
    endfunction

    function void write_register(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DROP_INBOUND_ON:  cfg.drop_inbound_on = data[0];
        REG_DROP_OUTBOUND_ON: cfg.drop_outbound_on = data[0];
        REG_DROP_CHANCE:      cfg.drop_chance = data[CHANCE_W-1:0];
        REG_LIMITER_ON: begin
          cfg.limiter_on = data[0];
          empty_window();
        end
        REG_WINDOW_PACKETS: begin
          cfg.window_packets = data[WPKT_W-1:0];
          empty_window();
        end
        REG_BYTE_LIMIT: begin
          cfg.byte_limit = data[LIMIT_W-1:0];
          empty_window();
        end
        default: ;
      endcase
    endfunction

    function void note_packet(logic [LEN_W-1:0] len, logic outbound,
                              logic [CHANCE_W-1:0] draw);
      logic        dir_on;
      logic        hit;
      int unsigned span;
      int unsigned pos;
      int unsigned evicted;
      int unsigned base;
      int unsigned want;
      fate_t       fate;
      dir_on = outbound ? cfg.drop_outbound_on : cfg.drop_inbound_on;
      hit = (cfg.drop_chance >= FULL_CHANCE) || (draw < cfg.drop_chance);
      fate.fwd  = 1'b1;
      fate.code = VERDICT_FORWARD;
      if (dir_on && hit) begin
        fate.fwd  = 1'b0;
        fate.code = VERDICT_RANDOM;
      end else if (cfg.limiter_on) begin
        span = cfg.window_packets;
        if (span == 0) span = 1;
        if (span > WINDOW_MAX) span = WINDOW_MAX;
        pos = slot_next % span;
        // Once the window is full the slot about to be written holds the oldest length.
        evicted = (held >= span) ? length_hist[pos] : 0;
        base = (bytes_held >= evicted) ? bytes_held - evicted : 0;
        want = base + len;
        if (want <= cfg.byte_limit) begin
          length_hist[pos] = len;
          bytes_held = want & 32'hFF_FFFF;
          slot_next = (pos + 1) % span;
          if (held < span) held++;
        end else begin
          fate.fwd  = 1'b0;
          fate.code = VERDICT_LIMIT;
        end
      end
      fates_due.push_back(fate);
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_MISMATCH_LINES)
        $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_verdict(logic fwd, logic [1:0] code);
      fate_t due;
      if (fates_due.size() == 0) begin
        report_mismatch($sformatf("result fwd=%0b verdict=%0d with no packet pending",
                                  fwd, code));
      end else begin
        due = fates_due.pop_front();
        if (fwd !== due.fwd)
          report_mismatch($sformatf("forward got %0b want %0b", fwd, due.fwd));
        if (code !== due.code)
          report_mismatch($sformatf("verdict got %0d want %0d", code, due.code));
      end
    endtask

    function int outstanding();
      return fates_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [LEN_W-1:0]    packet_length = '0;
  logic                is_outbound = 1'b0;
  logic [CHANCE_W-1:0] random_draw = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                forward;
  logic [1:0]          verdict;

  packet_fate_predictor fates = new();
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned hold_off_cycles = 0;
  int unsigned quiet_edges = 0;

  packet_drop_byte_window_limiter_top #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .packet_length(packet_length),
    .is_outbound(is_outbound),
    .random_draw(random_draw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .forward(forward),
    .verdict(verdict)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Both transfers are taken from values sampled at the edge; the input is noted first
  // so the prediction exists even for a result that follows with no delay.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        fates.note_packet(packet_length, is_outbound, random_draw);
      if (out_valid && !out_stall)
        fates.check_verdict(forward, verdict);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_edges = 0;
      end else begin
        quiet_edges++;
        if (quiet_edges >= QUIET_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(0, 99) < 19);
      end
    end
  end

  function automatic packet_t pkt(int unsigned len, bit outbound, int unsigned draw);
    packet_t p;
    p.len      = len;
    p.outbound = outbound;
    p.draw     = draw;
    return p;
  endfunction

  function automatic packet_t random_packet();
    packet_t p;
    case ($urandom_range(0, 7))
      0:       p.len = '0;
      1:       p.len = '1;
      2:       p.len = $urandom;
      default: p.len = $urandom_range(1, 1500);
    endcase
    p.outbound = $urandom_range(0, 1);
    case ($urandom_range(0, 5))
      0:       p.draw = $urandom;
      1:       p.draw = '1;
      default: p.draw = $urandom_range(0, 9999);
    endcase
    return p;
  endfunction

  // Now and then the bits above the register's width carry junk that must be ignored.
  function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] value, int unsigned width);
    logic [CFG_W-1:0] mask;
    mask = (24'h1 << width) - 24'h1;
    if ($urandom_range(0, 3) == 0)
      return (CFG_W'($urandom) & ~mask) | (value & mask);
    return value & mask;
  endfunction

  task automatic wait_drained();
    while (fates.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    fates.write_register(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_packets(packet_t list [$]);
    foreach (list[i]) begin
      while (tx_idle_on && $urandom_range(0, 99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid      <= 1'b1;
      packet_length <= list[i].len;
      is_outbound   <= list[i].outbound;
      random_draw   <= list[i].draw;
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
  endtask

  task automatic random_settings();
    int unsigned chance;
    int unsigned span;
    int unsigned limit;
    case ($urandom_range(0, 5))
      0:       chance = 0;
      1:       chance = 10000;
      2:       chance = $urandom_range(0, 16383);
      default: chance = $urandom_range(0, 3000);
    endcase
    case ($urandom_range(0, 5))
      0:       span = $urandom_range(0, 511);
      1:       span = WINDOW_MAX;
      2:       span = 0;
      default: span = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 4))
      0:       limit = $urandom_range(0, 3000);
      1:       limit = 24'hFF_FFFF;
      2:       limit = $urandom & 24'hFF_FFFF;
      default: limit = $urandom_range(500, 12000);
    endcase
    write_reg(REG_DROP_INBOUND_ON, with_junk($urandom_range(0, 1), 1));
    write_reg(REG_DROP_OUTBOUND_ON, with_junk($urandom_range(0, 1), 1));
    write_reg(REG_DROP_CHANCE, with_junk(chance, CHANCE_W));
    write_reg(REG_LIMITER_ON, with_junk($urandom_range(0, 3) != 0, 1));
    write_reg(REG_WINDOW_PACKETS, with_junk(span, WPKT_W));
    write_reg(REG_BYTE_LIMIT, limit);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom);
  endtask

  initial begin
    packet_t burst [$];
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Power-on settings: random drop below 1000 on both directions, limiter off.
    burst = '{pkt(0, 0, 0), pkt(65535, 1, 999), pkt(65535, 0, 1000), pkt(1500, 1, 16383)};
    send_packets(burst);

    write_reg(REG_DROP_INBOUND_ON, 0);
    write_reg(REG_DROP_CHANCE, 10000);
    burst = '{pkt(100, 0, 0), pkt(100, 1, 16383)};
    send_packets(burst);

    write_reg(REG_DROP_OUTBOUND_ON, 0);
    write_reg(REG_DROP_CHANCE, 16383);
    write_reg(REG_UNMAPPED_LO, 24'hFF_FFFF);
    write_reg(REG_UNMAPPED_HI, 24'hFF_FFFF);
    burst = '{pkt(7, 1, 0), pkt(9, 0, 16383)};
    send_packets(burst);

    write_reg(REG_DROP_INBOUND_ON, 1);
    write_reg(REG_DROP_OUTBOUND_ON, 1);
    write_reg(REG_DROP_CHANCE, 0);
    write_reg(REG_LIMITER_ON, 1);
    write_reg(REG_WINDOW_PACKETS, 3);
    write_reg(REG_BYTE_LIMIT, 100);
    burst = '{pkt(40, 0, 0), pkt(40, 1, 5), pkt(30, 0, 0), pkt(20, 1, 0),
              pkt(50, 0, 0), pkt(0, 1, 0), pkt(41, 0, 0)};
    send_packets(burst);

    // A zero byte limit admits only empty packets.
    write_reg(REG_BYTE_LIMIT, 0);
    burst = '{pkt(0, 0, 0), pkt(1, 1, 0)};
    send_packets(burst);

    // A window size of zero behaves as one.
    write_reg(REG_WINDOW_PACKETS, 0);
    write_reg(REG_BYTE_LIMIT, 65535);
    burst = '{pkt(65535, 0, 0), pkt(65535, 1, 0), pkt(1, 0, 0)};
    send_packets(burst);

    // Sizes above the ring depth clamp to the full ring.
    write_reg(REG_WINDOW_PACKETS, 511);
    write_reg(REG_BYTE_LIMIT, 24'hFF_FFFF);
    burst = '{pkt(65535, 0, 0), pkt(65535, 1, 0), pkt(65535, 0, 0)};
    send_packets(burst);

    write_reg(REG_LIMITER_ON, 0);
    burst = '{pkt(65535, 1, 0)};
    send_packets(burst);

    for (int phase = 0; phase < 9; phase++) begin
      tx_idle_on = (phase != 2);
      rx_idle_on = (phase != 2);
      random_settings();
      burst = {};
      repeat (phase == 1 ? 40 : 100) burst.push_back(random_packet());
      if (phase == 1) begin
        // The receiver holds off while packets keep coming, so the block backs up.
        hold_off_cycles = HOLD_OFF_CYCLES;
        send_packets(burst);
      end else if (phase == 4) begin
        send_packets(burst[0:49]);
        wait_drained();
        send_packets(burst[50:99]);
      end else begin
        send_packets(burst);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fates.errors == 0 && fates.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
